/* rtl/stq_pkg.sv */
// Shared types, widths, constants and tables for the stick-to-quaternion block.
`default_nettype none
package stq_pkg;

   typedef struct packed {
      logic        [15:0] thrust_cmd;
      logic signed [15:0] roll_stick;
      logic signed [15:0] pitch_stick;
      logic signed [15:0] yaw_stick;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } rsp_type;

   localparam int APPROX_ITERATIONS_DEF = 16;
   localparam int ATAN_DEPTH = 24;

   localparam int GAIN_W  = 24;
   localparam int MAG_W   = 33;
   localparam int PROD_W  = 2 * MAG_W;
   localparam int DIGIT_W = 4;
   localparam int SUM_W   = 56;
   localparam int ROOT_W  = SUM_W / 2;
   localparam int ANG_W   = 35;
   localparam int CS_W    = 33;
   localparam int NUM_W   = 62;
   localparam int QUO_W   = 18;
   localparam int YAW_W   = 29;
   localparam int RAD_W   = 25;

   localparam logic        [15:0]       THRUST_MIN      = 16'd6554;
   localparam logic signed [15:0]       YAW_DEADBAND    = 16'sd1639;
   localparam logic signed [21:0]       DEG_LIMIT       = 22'sd983040;
   localparam logic        [26:0]       PI_OVER_180_Q32 = 27'd74961321;
   localparam logic signed [29:0]       YAW_LIMIT       = 30'sd134217728;
   localparam logic signed [ANG_W-1:0]  PI_Q30          = 35'sd3373259426;
   localparam logic        [32:0]       HALF_PI_Q30     = 33'd1686629713;
   localparam logic signed [CS_W-1:0]   CORDIC_GAIN_Q30 = 33'sd652032874;
   localparam logic        [GAIN_W-1:0] GAIN_RESET      = 24'd105414;

   function automatic logic [30:0] atan_q30(input logic [4:0] idx);
      logic [30:0] val;
      unique case (idx)
         5'd0:  val = 31'd843314857;
         5'd1:  val = 31'd497837829;
         5'd2:  val = 31'd263043837;
         5'd3:  val = 31'd133525159;
         5'd4:  val = 31'd67021687;
         5'd5:  val = 31'd33543516;
         5'd6:  val = 31'd16775851;
         5'd7:  val = 31'd8388437;
         5'd8:  val = 31'd4194283;
         5'd9:  val = 31'd2097149;
         5'd10: val = 31'd1048576;
         5'd11: val = 31'd524288;
         5'd12: val = 31'd262144;
         5'd13: val = 31'd131072;
         5'd14: val = 31'd65536;
         5'd15: val = 31'd32768;
         5'd16: val = 31'd16384;
         5'd17: val = 31'd8192;
         5'd18: val = 31'd4096;
         5'd19: val = 31'd2048;
         5'd20: val = 31'd1024;
         5'd21: val = 31'd512;
         5'd22: val = 31'd256;
         5'd23: val = 31'd128;
         default: val = 31'd0;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

/* rtl/stq_mul.sv */
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle.
`default_nettype none
module stq_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [stq_pkg::MAG_W-1:0]  a,
   input  logic [stq_pkg::MAG_W-1:0]  b,
   output logic                       done,
   output logic [stq_pkg::PROD_W-1:0] product
);
   import stq_pkg::*;

   localparam int DIGITS = (MAG_W + DIGIT_W - 1) / DIGIT_W;
   localparam int BW     = DIGITS * DIGIT_W;
   localparam int AW     = MAG_W + BW;
   localparam int CW     = $clog2(DIGITS);
   localparam logic [CW-1:0] LAST = CW'(DIGITS - 1);

   logic [MAG_W-1:0]         a_ff;
   logic [BW-1:0]            b_ff, b_in;
   logic [AW-1:0]            acc_ff, acc_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;
   logic [MAG_W+DIGIT_W-1:0] part;

   always_comb begin
      part    = a_ff * b_ff[BW-1 -: DIGIT_W];
      acc_in  = (acc_ff << DIGIT_W) + AW'(part);
      b_in    = b_ff << DIGIT_W;
      cnt_in  = cnt_ff + 1'b1;
      busy_in = busy_ff && (cnt_ff != LAST);
      done_in = busy_ff && (cnt_ff == LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (busy_ff) cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= BW'(b);
         acc_ff <= '0;
      end else if (busy_ff) begin
         b_ff   <= b_in;
         acc_ff <= acc_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff[PROD_W-1:0];

endmodule
`default_nettype wire

/* rtl/stq_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module stq_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [stq_pkg::NUM_W-1:0] numer,
   input  logic [stq_pkg::NUM_W-1:0] denom,
   output logic                      done,
   output logic [stq_pkg::QUO_W-1:0] quot
);
   import stq_pkg::*;

   localparam int CW = $clog2(QUO_W);
   localparam logic [CW-1:0] LAST = CW'(QUO_W - 1);

   logic [NUM_W-1:0] rem_ff, rem_in, d_ff;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff, ge;

   always_comb begin
      ge     = rem_ff >= d_ff;
      rem_in = ge ? rem_ff - d_ff : rem_ff;
      q_in   = {q_ff[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_ff && (cnt_ff != LAST);
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (busy_ff) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= numer;
         d_ff   <= denom << (QUO_W - 1);
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         d_ff   <= d_ff >> 1;
         q_ff   <= q_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

/* rtl/stq_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module stq_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [stq_pkg::SUM_W-1:0]  radicand,
   output logic                       done,
   output logic [stq_pkg::ROOT_W-1:0] root
);
   import stq_pkg::*;

   localparam int CW = $clog2(ROOT_W);
   localparam logic [CW-1:0] LAST = CW'(ROOT_W - 1);

   logic [SUM_W-1:0] v_ff, v_in, r_ff, r_in, bit_ff;
   logic [SUM_W:0]   trial;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff, ge;

   always_comb begin
      trial = {1'b0, r_ff} + {1'b0, bit_ff};
      ge    = {1'b0, v_ff} >= trial;
      v_in  = ge ? v_ff - trial[SUM_W-1:0] : v_ff;
      r_in  = ge ? (r_ff >> 1) + bit_ff : r_ff >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_ff && (cnt_ff != LAST);
         done_ff <= busy_ff && (cnt_ff == LAST);
         if (busy_ff) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         v_ff   <= radicand;
         r_ff   <= '0;
         bit_ff <= SUM_W'(1) << (SUM_W - 2);
      end else if (busy_ff) begin
         v_ff   <= v_in;
         r_ff   <= r_in;
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = r_ff[ROOT_W-1:0];

endmodule
`default_nettype wire

/* rtl/stq_cordic.sv */
// Rotation-mode CORDIC for sine and cosine, one micro-rotation per cycle.
`default_nettype none
module stq_cordic #(
   parameter int ITERATIONS = stq_pkg::APPROX_ITERATIONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [stq_pkg::ANG_W-1:0] angle,
   output logic                            done,
   output logic signed [stq_pkg::CS_W-1:0] cos_out,
   output logic signed [stq_pkg::CS_W-1:0] sin_out
);
   import stq_pkg::*;

   localparam int STEPS = (ITERATIONS < ATAN_DEPTH) ? ITERATIONS : ATAN_DEPTH;
   localparam int CW = $clog2(STEPS);
   localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

   logic signed [CS_W-1:0]  x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ANG_W-1:0] z_ff, z_in, step;
   logic [CW-1:0]           i_ff;
   logic                    busy_ff, done_ff, z_pos;

   always_comb begin
      dx    = y_ff >>> i_ff;
      dy    = x_ff >>> i_ff;
      step  = $signed({{(ANG_W-31){1'b0}}, atan_q30(5'(i_ff))});
      z_pos = !z_ff[ANG_W-1];
      x_in  = z_pos ? x_ff - dx : x_ff + dx;
      y_in  = z_pos ? y_ff + dy : y_ff - dy;
      z_in  = z_pos ? z_ff - step : z_ff + step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_ff && (i_ff != LAST);
         done_ff <= busy_ff && (i_ff == LAST);
         if (busy_ff) i_ff <= i_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_GAIN_Q30;
         y_ff <= '0;
         z_ff <= angle;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign done    = done_ff;
   assign cos_out = x_ff;
   assign sin_out = y_ff;

endmodule
`default_nettype wire

/* rtl/stick_to_attitude_quaternion.sv */
// Stick-to-attitude quaternion top level: sequencer, yaw state, shared arithmetic units.
//
// One stick request in, one Q1.15 attitude quaternion out. Requests are taken one at a
// time; each goes through three digit-serial multiplies for yaw, roll and pitch, three
// squares, a square root, a CORDIC and three multiply-divide pairs. Yaw work is skipped
// at low thrust or inside the yaw deadband, and everything after the square root when
// the rotation is zero.
// A finished quaternion waits in the output register while the next request is taken.
// The user must write yaw_gain through csr_wr_en/csr_wr_data only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module stick_to_attitude_quaternion #(
   parameter int APPROX_ITERATIONS = stq_pkg::APPROX_ITERATIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  stq_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output stq_pkg::rsp_type           rsp_data,
   input  logic                       csr_wr_en,
   input  logic [stq_pkg::GAIN_W-1:0] csr_wr_data
);
   import stq_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_YAW  = 9'b000000010,
      ST_RAD  = 9'b000000100,
      ST_SQR  = 9'b000001000,
      ST_ROOT = 9'b000010000,
      ST_ROT  = 9'b000100000,
      ST_PROD = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   function automatic logic signed [15:0] sat_signed(input logic neg, input logic [18:0] q);
      logic signed [15:0] r;
      if (neg) r = (q > 19'd32768) ? -16'sd32768 : 16'(-q);
      else     r = (q > 19'd32767) ? 16'sd32767 : 16'(q);
      return r;
   endfunction

   state_type state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic go_ff, go_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic signed [YAW_W-1:0] yaw_ff, yaw_in;
   logic signed [15:0] roll_ff, pitch_ff, ys_ff;
   logic signed [RAD_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ROOT_W-1:0] n_ff, n_in;
   logic signed [ANG_W-1:0] angle_ff, angle_in;
   logic flip_ff, flip_in, sign_ff, sign_in;
   logic signed [CS_W-1:0] sin_ff, sin_in;
   logic [NUM_W-1:0] num_ff, num_in;
   rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in, load;
   logic req_accept, low_thrust, yaw_active;

   logic [MAG_W-1:0] mul_a, mul_b;
   logic [PROD_W-1:0] mul_product;
   logic mul_done, sqrt_done, cordic_done, div_done;
   logic [ROOT_W-1:0] root;
   logic signed [CS_W-1:0] cos_val, sin_val;
   logic [QUO_W-1:0] quot;

   logic [15:0] ys_mag;
   logic signed [15:0] stick_sel;
   logic signed [21:0] deg_raw, deg_clamp, deg_neg_val;
   logic [19:0] deg_mag;
   logic signed [YAW_W-1:0] comp_sel;
   logic [YAW_W-1:0] comp_mag;
   logic [CS_W-1:0] sin_mag;
   logic signed [41:0] yaw_prod, yaw_inc;
   logic signed [29:0] yaw_sum;
   logic [47:0] rad_round;
   logic [RAD_W-1:0] rad_mag;
   logic signed [RAD_W-1:0] rad_val;
   logic [32:0] half_ang;
   logic signed [33:0] cos_adj;
   logic [33:0] cos_mag;
   logic [33:0] cos_rnd;
   logic signed [15:0] div_res;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign low_thrust = req_data.thrust_cmd < THRUST_MIN;
   assign yaw_active = (req_data.yaw_stick >= YAW_DEADBAND)
                    || (req_data.yaw_stick <= -YAW_DEADBAND);

   // operand preparation
   always_comb begin
      ys_mag      = ys_ff[15] ? 16'(-ys_ff) : 16'(ys_ff);
      stick_sel   = idx_ff[0] ? pitch_ff : roll_ff;
      deg_raw     = (22'(stick_sel) <<< 5) + (22'(stick_sel) <<< 3)
                  + (22'(stick_sel) <<< 2) + 22'(stick_sel);
      deg_neg_val = -DEG_LIMIT;
      if (deg_raw > DEG_LIMIT)        deg_clamp = DEG_LIMIT;
      else if (deg_raw < deg_neg_val) deg_clamp = deg_neg_val;
      else                            deg_clamp = deg_raw;
      deg_mag = deg_clamp[21] ? 20'(-deg_clamp) : 20'(deg_clamp);
      unique case (idx_ff)
         2'd0:    comp_sel = YAW_W'(rx_ff);
         2'd1:    comp_sel = YAW_W'(ry_ff);
         default: comp_sel = yaw_ff;
      endcase
      comp_mag = comp_sel[YAW_W-1] ? YAW_W'(-comp_sel) : YAW_W'(comp_sel);
      sin_mag  = sin_ff[CS_W-1] ? CS_W'(-sin_ff) : CS_W'(sin_ff);
      mul_a = MAG_W'(comp_mag);
      mul_b = sin_mag;
      unique case (state_ff)
         ST_YAW: begin
            mul_a = MAG_W'(ys_mag);
            mul_b = MAG_W'(gain_ff);
         end
         ST_RAD: begin
            mul_a = MAG_W'(deg_mag);
            mul_b = MAG_W'(PI_OVER_180_Q32);
         end
         ST_SQR: begin
            mul_a = MAG_W'(comp_mag);
            mul_b = MAG_W'(comp_mag);
         end
         default: ;
      endcase
   end

   // result post-processing
   always_comb begin
      yaw_prod  = ys_ff[15] ? -$signed({2'b00, mul_product[39:0]})
                            : $signed({2'b00, mul_product[39:0]});
      yaw_inc   = (yaw_prod + 42'sd16384) >>> 15;
      yaw_sum   = 30'(yaw_ff) + yaw_inc[29:0];
      rad_round = (mul_product[47:0] + 48'd4194304) >> 23;
      rad_mag   = {1'b0, rad_round[23:0]};
      rad_val   = deg_clamp[21] ? -$signed(rad_mag) : $signed(rad_mag);
      half_ang  = {root, 5'b00000};
      cos_adj   = flip_ff ? -34'(cos_val) : 34'(cos_val);
      cos_mag   = cos_adj[33] ? 34'(-cos_adj) : 34'(cos_adj);
      cos_rnd   = (cos_mag + 34'd16384) >> 15;
      div_res   = sat_signed(sign_ff, {1'b0, quot});
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      go_in    = 1'b0;
      yaw_in   = yaw_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      angle_in = angle_ff;
      flip_in  = flip_ff;
      sin_in   = sin_ff;
      num_in   = num_ff;
      sign_in  = sign_ff;
      res_in   = res_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               go_in  = 1'b1;
               idx_in = 2'd0;
               if (low_thrust) begin
                  yaw_in   = '0;
                  state_in = ST_RAD;
               end else if (yaw_active) begin
                  state_in = ST_YAW;
               end else begin
                  state_in = ST_RAD;
               end
            end
         end
         ST_YAW: begin
            if (mul_done) begin
               if (yaw_sum > YAW_LIMIT)       yaw_in = YAW_W'(YAW_LIMIT);
               else if (yaw_sum < -YAW_LIMIT) yaw_in = YAW_W'(-YAW_LIMIT);
               else                           yaw_in = YAW_W'(yaw_sum);
               state_in = ST_RAD;
               go_in    = 1'b1;
            end
         end
         ST_RAD: begin
            if (mul_done) begin
               go_in = 1'b1;
               if (idx_ff[0]) begin
                  ry_in    = rad_val;
                  idx_in   = 2'd0;
                  sum_in   = '0;
                  state_in = ST_SQR;
               end else begin
                  rx_in  = rad_val;
                  idx_in = 2'd1;
               end
            end
         end
         ST_SQR: begin
            if (mul_done) begin
               sum_in = sum_ff + mul_product[SUM_W-1:0];
               go_in  = 1'b1;
               if (idx_ff == 2'd2) state_in = ST_ROOT;
               else idx_in = idx_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               n_in = root;
               if (root == '0) begin
                  res_in.quat_w = 16'sd32767;
                  res_in.quat_x = '0;
                  res_in.quat_y = '0;
                  res_in.quat_z = '0;
                  state_in      = ST_OUT;
               end else begin
                  flip_in  = half_ang > HALF_PI_Q30;
                  angle_in = flip_in ? PI_Q30 - $signed({2'b00, half_ang})
                                     : $signed({2'b00, half_ang});
                  go_in    = 1'b1;
                  state_in = ST_ROT;
               end
            end
         end
         ST_ROT: begin
            if (cordic_done) begin
               res_in.quat_w = sat_signed(cos_adj[33], cos_rnd[18:0]);
               sin_in        = sin_val;
               idx_in        = 2'd0;
               go_in         = 1'b1;
               state_in      = ST_PROD;
            end
         end
         ST_PROD: begin
            if (mul_done) begin
               num_in   = NUM_W'(mul_product) + NUM_W'({n_ff, 14'b0});
               sign_in  = comp_sel[YAW_W-1] ^ sin_ff[CS_W-1];
               go_in    = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               unique case (idx_ff)
                  2'd0:    res_in.quat_x = div_res;
                  2'd1:    res_in.quat_y = div_res;
                  default: res_in.quat_z = div_res;
               endcase
               if (idx_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  go_in    = 1'b1;
                  state_in = ST_PROD;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_in       = load ? res_ff : rsp_ff;
      gain_in      = csr_wr_en ? csr_wr_data : gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         go_ff        <= 1'b0;
         gain_ff      <= GAIN_RESET;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         go_ff        <= go_in;
         gain_ff      <= gain_in;
         yaw_ff       <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         roll_ff  <= req_data.roll_stick;
         pitch_ff <= req_data.pitch_stick;
         ys_ff    <= req_data.yaw_stick;
      end
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      sum_ff   <= sum_in;
      n_ff     <= n_in;
      angle_ff <= angle_in;
      flip_ff  <= flip_in;
      sin_ff   <= sin_in;
      num_ff   <= num_in;
      sign_ff  <= sign_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   stq_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff && (state_ff == ST_YAW || state_ff == ST_RAD
                          || state_ff == ST_SQR || state_ff == ST_PROD)),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   stq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (go_ff && state_ff == ST_ROOT),
      .radicand (sum_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   stq_cordic #(.ITERATIONS(APPROX_ITERATIONS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff && state_ff == ST_ROT),
      .angle   (angle_ff),
      .done    (cordic_done),
      .cos_out (cos_val),
      .sin_out (sin_val)
   );

   stq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (go_ff && state_ff == ST_DIV),
      .numer (num_ff),
      .denom (NUM_W'({n_ff, 15'b0})),
      .done  (div_done),
      .quot  (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (30'(yaw_ff) <= YAW_LIMIT) && (30'(yaw_ff) >= -YAW_LIMIT))
      else $error("yaw angle out of range");

   a_low_thrust_clear: assert property (@(posedge clock) disable iff (reset)
      req_accept && low_thrust |=> yaw_ff == '0)
      else $error("yaw angle not cleared at low thrust");

   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_YAW || state_ff == ST_RAD
                    || state_ff == ST_SQR || state_ff == ST_PROD))
      else $error("multiplier finished outside a multiply step");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response loaded outside output step");

endmodule
`default_nettype wire

/* tb/tb_stick_to_attitude_quaternion.sv */
// Self-checking testbench for the stick-to-attitude quaternion block.
`default_nettype none
module tb_stick_to_attitude_quaternion;
   timeunit 1ns;
   timeprecision 1ps;
   import stq_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  N_RANDOM    = 730;
   localparam int  DRAIN_WAIT  = 300;
   localparam int  HOLD_CYCLES = 800;
   localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

   typedef struct {
      req_type r;
      bit      known;
      rsp_type q;
   } stim_row_type;

   localparam longint ARC_TAN [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   rsp_type           rsp_data;
   logic              csr_wr_en = 0;
   logic [GAIN_W-1:0] csr_wr_data = '0;

   rsp_type           quat_pending[$];
   logic [GAIN_W-1:0] gain_model;
   longint            yaw_model;
   int                errors = 0;
   int                cycles = 0;
   bit                long_hold = 0;
   bit                quiet = 0;

   stick_to_attitude_quaternion u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data));

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("stick_to_attitude_quaternion: mismatch");
         $finish;
      end
   end

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint stick_rad(logic signed [15:0] s);
      longint deg;
      deg = longint'(s) * 45;
      if (deg > 983040) deg = 983040;
      if (deg < -983040) deg = -983040;
      return round_div(deg * 74961321, longint'(1) << 23);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(root);
   endfunction

   // advances the yaw state and returns the expected quaternion
   function automatic rsp_type quat_of_sticks(req_type r);
      longint inc, acc, rx, ry, yw, mag, h, cx, sy, zz, dx, dy;
      bit flip;
      rsp_type q;
      flip = 0;
      if (r.thrust_cmd < 16'd6554) begin
         yaw_model = 0;
      end else if (r.yaw_stick >= 16'sd1639 || r.yaw_stick <= -16'sd1639) begin
         inc = (longint'(r.yaw_stick) * longint'(gain_model) + 16384) >>> 15;
         acc = yaw_model + inc;
         if (acc > 134217728) acc = 134217728;
         if (acc < -134217728) acc = -134217728;
         yaw_model = acc;
      end
      rx = stick_rad(r.roll_stick);
      ry = stick_rad(r.pitch_stick);
      yw = yaw_model;
      mag = int_sqrt(longint'(rx * rx + ry * ry + yw * yw));
      if (mag == 0) begin
         q = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0};
      end else begin
         h = mag * 32;
         if (h > 64'sd1686629713) begin
            h = 64'sd3373259426 - h;
            flip = 1;
         end
         cx = 652032874;
         sy = 0;
         zz = h;
         for (int i = 0; i < APPROX_ITERATIONS_DEF && i < 24; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (zz >= 0) begin
               cx -= dx; sy += dy; zz -= ARC_TAN[i];
            end else begin
               cx += dx; sy -= dy; zz += ARC_TAN[i];
            end
         end
         if (flip) cx = -cx;
         q.quat_w = 16'(clip16(round_div(cx, 64'sd32768)));
         q.quat_x = 16'(clip16(round_div(rx * sy, mag <<< 15)));
         q.quat_y = 16'(clip16(round_div(ry * sy, mag <<< 15)));
         q.quat_z = 16'(clip16(round_div(yw * sy, mag <<< 15)));
      end
      return q;
   endfunction

   function automatic int pause_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 90);
   endfunction

   // receiver: random back-pressure plus one long hold-off on request
   always @(posedge clock) begin
      int hold;
      if (reset) begin
         hold = 0;
         rsp_stall <= 0;
      end else begin
         if (long_hold && hold < HOLD_CYCLES) hold = HOLD_CYCLES + 1;
         if (hold > 0) hold = hold - 1;
         else if (!quiet && $urandom_range(0, 99) < 12) hold = pause_len();
         rsp_stall <= (hold > 0);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (quat_pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = quat_pending.pop_front();
            if (rsp_data.quat_w !== e.quat_w) begin
               $display("%0t: quat_w expected %0d actual %0d", $time, e.quat_w, rsp_data.quat_w);
               errors++;
            end
            if (rsp_data.quat_x !== e.quat_x) begin
               $display("%0t: quat_x expected %0d actual %0d", $time, e.quat_x, rsp_data.quat_x);
               errors++;
            end
            if (rsp_data.quat_y !== e.quat_y) begin
               $display("%0t: quat_y expected %0d actual %0d", $time, e.quat_y, rsp_data.quat_y);
               errors++;
            end
            if (rsp_data.quat_z !== e.quat_z) begin
               $display("%0t: quat_z expected %0d actual %0d", $time, e.quat_z, rsp_data.quat_z);
               errors++;
            end
         end
      end
   end

   task automatic send_request(req_type r, bit known, rsp_type q);
      rsp_type p;
      int gap;
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = quat_of_sticks(r);
      quat_pending.push_back(known ? q : p);
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 0;
         req_data <= req_type'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_gain(logic [GAIN_W-1:0] g);
      req_valid <= 0;
      @(posedge clock);
      while (quat_pending.size() != 0) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 0;
      gain_model = g;
   endtask

   function automatic req_type random_request();
      req_type r;
      int k;
      r = req_type'({$urandom, $urandom});
      k = $urandom_range(0, 99);
      if (k < 10) r.thrust_cmd = 16'($urandom_range(0, 6553));
      else if (k < 90) r.thrust_cmd = 16'($urandom_range(6554, 65535));
      k = $urandom_range(0, 99);
      if (k < 15) r.yaw_stick = 16'($signed($urandom_range(0, 3278)) - 1639);
      else if (k < 45) r.yaw_stick = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if ($urandom_range(0, 9) == 0) r.roll_stick = 0;
      if ($urandom_range(0, 9) == 0) r.pitch_stick = 0;
      return r;
   endfunction

   stim_row_type rows[$];
   rsp_type   ident;
   req_type   rq;
   logic [GAIN_W-1:0] gains[4];

   initial begin
      ident = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0};
      gain_model = GAIN_RESET;
      yaw_model = 0;
      rows = '{
         '{'{16'd0, 16'sd0, 16'sd0, 16'sd0}, 1, ident},
         '{'{16'd65535, 16'sd0, 16'sd0, 16'sd1638}, 1, ident},
         '{'{16'd65535, 16'sd0, 16'sd0, -16'sd1638}, 1, ident},
         '{'{16'd65535, 16'sd0, 16'sd0, 16'sd1639}, 0, ident},
         '{'{16'd65535, 16'sd0, 16'sd0, -16'sd1639}, 0, ident},
         '{'{16'd6553, 16'sd0, 16'sd0, 16'sh7fff}, 1, ident},
         '{'{16'd6554, 16'sd0, 16'sd0, 16'sh7fff}, 0, ident},
         '{'{16'd6554, 16'sd0, 16'sd0, 16'sh8000}, 0, ident},
         '{'{16'd0, 16'sh7fff, 16'sd0, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sh8000, 16'sd0, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sd0, 16'sh7fff, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sd0, 16'sh8000, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sh7fff, 16'sh8000, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sd21845, 16'sd21845, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sd1, 16'sd0, 16'sd0}, 0, ident},
         '{'{16'd0, 16'sd0, -16'sd1, 16'sd0}, 0, ident},
         '{'{16'd40000, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0, ident},
         '{'{16'd65535, 16'sh8000, 16'sh8000, 16'sh8000}, 0, ident}};

      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (rows[i]) send_request(rows[i].r, rows[i].known, rows[i].q);

      // full gain: yaw saturates within the first ten requests and the half angle passes pi/2
      write_gain(GAIN_MAX);
      for (int i = 0; i < 10; i++)
         send_request('{16'd65535, 16'sd0, 16'sd0, 16'sh7fff}, 0, ident);
      for (int i = 0; i < 20; i++)
         send_request('{16'd65535, 16'sd0, 16'sd0, 16'sh8000}, 0, ident);

      gains = '{GAIN_MAX, 24'd0, GAIN_RESET, 24'($urandom_range(1, 16777214))};
      for (int p = 0; p < 4; p++) begin
         write_gain(gains[p]);
         quiet = (p == 2);
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            if (p == 1 && i == 20) begin
               long_hold = 1;
               fork
                  begin
                     repeat (HOLD_CYCLES + 5) @(posedge clock);
                     long_hold = 0;
                  end
               join_none
            end
            rq = random_request();
            send_request(rq, 0, ident);
         end
      end
      quiet = 0;
      req_valid <= 0;
      while (quat_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("stick_to_attitude_quaternion: match");
      end else begin
         $display("stick_to_attitude_quaternion: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire
